>>> src/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg: shared definitions of the square window minimum filter
// Sizes, sample and pixel types, the window cell record and helper functions.
// ----------------------------------------------------------------------------
package swmf_pkg;

	localparam int MAX_RADIUS  = 3;
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int SAMPLE_BITS = 8;

	localparam int NCHAN    = 3;
	localparam int NROWS    = 2 * MAX_RADIUS + 1;
	localparam int PIX_W    = NCHAN * SAMPLE_BITS;
	localparam int CFG_W    = 11;
	localparam int COORD_W  = 10;
	localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int WID_W    = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
	localparam int CROW_W   = $clog2(MAX_HEIGHT);
	localparam int ROW_W    = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 2);
	localparam int SLOT_W   = $clog2(NROWS);
	localparam int POS_W    = $clog2(MAX_HEIGHT * MAX_WIDTH + MAX_RADIUS * MAX_WIDTH
		+ MAX_RADIUS + 2);
	localparam int IN_DATA_W  = ((PIX_W + 7) / 8) * 8;
	localparam int OUT_BITS   = PIX_W + 2 * COORD_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_COLOR  = 2'd3
	} cfg_reg_t;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [NCHAN-1:0] pixel_t;

	// one column of the window: vertical minimum over valid rows, center sample
	typedef struct packed {
		pixel_t vmin;
		pixel_t ctr;
		logic   xok;
	} cell_t;

	function automatic sample_t sample_min(input sample_t a, input sample_t b);
		return (b < a) ? b : a;
	endfunction

	function automatic pixel_t pixel_min(input pixel_t a, input pixel_t b);
		pixel_t m;
		for (int ch = 0; ch < NCHAN; ch++) begin
			m[ch] = sample_min(a[ch], b[ch]);
		end
		return m;
	endfunction

endpackage

>>> src/swmf_ram.sv
// ----------------------------------------------------------------------------
// swmf_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/swmf_cell.sv
// ----------------------------------------------------------------------------
// swmf_cell: one column cell of the window chain
// Holds one column record, takes its neighbor's record on each shift and
// offers its masked minimum to the horizontal reduction.
// ----------------------------------------------------------------------------
module swmf_cell
	import swmf_pkg::*;
(
	input  logic   clk,
	input  logic   shift,
	input  cell_t  din,
	input  logic   in_window,
	output cell_t  dout,
	output pixel_t contrib
);

	cell_t data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;

	// columns outside the window or too close to a side edge count as neutral
	always_comb begin
		for (int ch = 0; ch < NCHAN; ch++) begin
			contrib[ch] = (in_window && data_q.xok) ? data_q.vmin[ch] : '1;
		end
	end

endmodule

>>> src/square_window_min_filter.sv
// ----------------------------------------------------------------------------
// square_window_min_filter: per channel minimum over a square pixel window
// Raster pixel stream in, window minimum per center pixel out, lagging by
// radius rows and radius pixels. Row banks hold the recent rows, a chain of
// column cells holds the vertical minima of the window columns.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata pixel, s_tuser drain flag
//  m_*      out  m_tvalid/m_tready  m_tdata minima and position, m_tlast frame end
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One pixel per clock while m_* does not stall; the result of the transfer that
// completes a window passes bank read, vertical min, horizontal min, then m_*.
// Row banks are single write, single read RAMs, one per buffered row.
// Reset or any register write restarts the frame position counters.
// A stall on m_* fills the output register, then the two inner stages.
// ----------------------------------------------------------------------------
module square_window_min_filter
	import swmf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // red_or_gray, green, blue
	input  logic                  s_tuser,  // drain
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // out_red_or_gray, out_green, out_blue,
	                                        // out_column, out_row, zero fill
	output logic                  m_tlast,  // frame_end
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int EXT_W = ROW_W + 2;

	// configuration
	logic [1:0]       radius_q;
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             color_q;
	logic [RAD_W-1:0] rad;
	logic [WID_W-1:0] w_eff;
	logic [HGT_W-1:0] h_eff;
	logic [POS_W-1:0] lag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 2'd1;
			width_q  <= CFG_W'(1024);
			height_q <= CFG_W'(1024);
			color_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_COLOR:  color_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rad = (32'(radius_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_q);
		if (width_q == '0) begin
			w_eff = WID_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HGT_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HGT_W'(MAX_HEIGHT);
		end else begin
			h_eff = HGT_W'(height_q);
		end
		lag = POS_W'(rad) * POS_W'(w_eff) + POS_W'(rad);
	end

	// handshake of the stages
	logic v_s1, v_s2, out_v_q;
	logic out_rdy, s2_free, s1_free, adv1, acc;

	assign out_rdy  = !out_v_q || m_tready;
	assign s2_free  = !v_s2 || out_rdy;
	assign s1_free  = !v_s1 || s2_free;
	assign adv1     = v_s1 && s2_free;
	assign s_tready = s1_free;
	assign acc      = s_tvalid && s_tready;

	// input position counters
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [POS_W-1:0]  pos_q;
	logic [SLOT_W-1:0] slot_q;
	logic [COL_W-1:0]  ccol_q;
	logic [CROW_W-1:0] crow_q;

	logic in_frame, counts, emit, fe, col_wrap, ccol_wrap;

	assign in_frame  = EXT_W'(row_q) < EXT_W'(h_eff);
	assign counts    = acc && !(in_frame && s_tuser);
	assign emit      = pos_q >= lag;
	assign col_wrap  = (WID_W'(col_q) + WID_W'(1)) == w_eff;
	assign ccol_wrap = (WID_W'(ccol_q) + WID_W'(1)) == w_eff;
	assign fe        = emit && ccol_wrap && (HGT_W'(crow_q) + HGT_W'(1) == h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pos_q  <= '0;
			slot_q <= '0;
			ccol_q <= '0;
			crow_q <= '0;
		end else if (cfg_we || (counts && fe)) begin
			col_q  <= '0;
			row_q  <= '0;
			pos_q  <= '0;
			slot_q <= '0;
			ccol_q <= '0;
			crow_q <= '0;
		end else if (counts) begin
			pos_q <= pos_q + POS_W'(1);
			if (col_wrap) begin
				col_q  <= '0;
				row_q  <= row_q + ROW_W'(1);
				slot_q <= (32'(slot_q) == NROWS - 1) ? '0 : slot_q + SLOT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
			if (emit) begin
				if (ccol_wrap) begin
					ccol_q <= '0;
					crow_q <= crow_q + CROW_W'(1);
				end else begin
					ccol_q <= ccol_q + COL_W'(1);
				end
			end
		end
	end

	// row validity of each buffered row, column validity of this column
	logic [NROWS-1:0] rowok;
	logic             xok;

	always_comb begin
		logic [EXT_W-1:0] rr, re, he;
		rr = EXT_W'(row_q);
		re = EXT_W'(rad);
		he = EXT_W'(h_eff);
		for (int d = 0; d < NROWS; d++) begin
			rowok[d] = (EXT_W'(d) <= (re << 1)) && (rr >= EXT_W'(d) + re)
				&& (rr + re < he + EXT_W'(d));
		end
		xok = (WID_W'(col_q) >= WID_W'(rad)) && (WID_W'(col_q) + WID_W'(rad) < w_eff);
	end

	// row banks
	pixel_t in_pix;
	pixel_t bank_rd [NROWS];

	assign in_pix = s_tdata[PIX_W-1:0];

	for (genvar b = 0; b < NROWS; b++) begin : g_bank
		swmf_ram #(
			.WIDTH (PIX_W),
			.DEPTH (MAX_WIDTH)
		) u_bank (
			.clk   (clk),
			.we    (counts && in_frame && (32'(slot_q) == b)),
			.waddr (col_q),
			.wdata (in_pix),
			.re    (counts),
			.raddr (col_q),
			.rdata (bank_rd[b])
		);
	end

	// stage 1: bank data back, vertical minimum
	pixel_t            pix_s1;
	logic [NROWS-1:0]  rowok_s1;
	logic              xok_s1, emit_s1, fe_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [COL_W-1:0]  ccol_s1;
	logic [CROW_W-1:0] crow_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= counts;
		end
	end

	always_ff @(posedge clk) begin
		if (counts) begin
			pix_s1   <= in_pix;
			rowok_s1 <= rowok;
			xok_s1   <= xok;
			emit_s1  <= emit;
			fe_s1    <= fe;
			slot_s1  <= slot_q;
			ccol_s1  <= ccol_q;
			crow_s1  <= crow_q;
		end
	end

	function automatic logic [SLOT_W-1:0] bank_of(input logic [SLOT_W-1:0] slot,
		input int d);
		logic [SLOT_W:0] s;
		s = (SLOT_W+1)'(slot) + (SLOT_W+1)'(NROWS - d);
		if (s >= (SLOT_W+1)'(NROWS)) begin
			s = s - (SLOT_W+1)'(NROWS);
		end
		return s[SLOT_W-1:0];
	endfunction

	pixel_t rows_s1 [NROWS];
	cell_t  new_cell;

	always_comb begin
		pixel_t vm;
		rows_s1[0] = pix_s1;
		for (int d = 1; d < NROWS; d++) begin
			rows_s1[d] = bank_rd[bank_of(slot_s1, d)];
		end
		vm = '1;
		for (int d = 0; d < NROWS; d++) begin
			if (rowok_s1[d]) begin
				vm = pixel_min(vm, rows_s1[d]);
			end
		end
		new_cell.vmin = vm;
		new_cell.ctr  = rows_s1[SLOT_W'(rad)];
		new_cell.xok  = xok_s1;
	end

	// chain of column cells, cell k holds the column k places back
	cell_t  cell_out [NROWS];
	pixel_t contrib  [NROWS];

	for (genvar k = 0; k < NROWS; k++) begin : g_cell
		swmf_cell u_cell (
			.clk       (clk),
			.shift     (adv1),
			.din       ((k == 0) ? new_cell : cell_out[(k == 0) ? 0 : k - 1]),
			.in_window (32'(rad) * 2 >= k),
			.dout      (cell_out[k]),
			.contrib   (contrib[k])
		);
	end

	// stage 2: horizontal minimum over the chain
	logic [COL_W-1:0]  ccol_s2;
	logic [CROW_W-1:0] crow_s2;
	logic              fe_s2;
	pixel_t            hmin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ccol_s2 <= ccol_s1;
			crow_s2 <= crow_s1;
			fe_s2   <= fe_s1;
		end
	end

	always_comb begin
		hmin = cell_out[SLOT_W'(rad)].ctr;
		for (int k = 0; k < NROWS; k++) begin
			hmin = pixel_min(hmin, contrib[k]);
		end
	end

	// output register
	pixel_t            res_q;
	logic [COL_W-1:0]  ocol_q;
	logic [CROW_W-1:0] orow_q;
	logic              ofe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_rdy) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && out_rdy) begin
			res_q[0] <= hmin[0];
			// gray mode reports zero on the unused channels
			for (int ch = 1; ch < NCHAN; ch++) begin
				res_q[ch] <= color_q ? hmin[ch] : '0;
			end
			ocol_q <= ccol_s2;
			orow_q <= crow_s2;
			ofe_q  <= fe_s2;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = ofe_q;
	assign m_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), COORD_W'(orow_q), COORD_W'(ocol_q),
		res_q};

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: square window minimum filter
// Drives raster frames and drain items through the pixel stream, keeps its own
// line memory to predict every window minimum and checks each output transfer
// field by field. Frame size, radius and color mode change between phases.
// ----------------------------------------------------------------------------
module testbench;
	import swmf_pkg::*;

	typedef struct packed {
		logic    drain;
		sample_t b;
		sample_t g;
		sample_t r;
	} pix_item_t;

	typedef struct packed {
		logic                fend;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
		sample_t             b;
		sample_t             g;
		sample_t             r;
	} min_result_t;

	logic                  clk, arst_n;
	logic                  s_tvalid, s_tready, s_tuser;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid, m_tready, m_tlast;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	square_window_min_filter dut (.*);

	// predictor state
	sample_t     rows_mem [NROWS*MAX_WIDTH][3];
	int unsigned cur_col, cur_row;
	int unsigned k_rad, k_wid, k_hgt, k_rgb;

	pix_item_t   pending_px[$];
	min_result_t expected_min[$];
	int          errors;
	int          mismatches;
	int          send_idle_pct, recv_stall_pct;
	int          hold_off;
	int          quiet_cycles;
	bit          in_taken;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned mem_idx(int unsigned row, int unsigned col);
		return (row % NROWS) * MAX_WIDTH + (col % MAX_WIDTH);
	endfunction

	// window minimum over neighbors clear of the frame border, center always counts
	function automatic void predict_min(pix_item_t it);
		int unsigned p, lag, q, rc, cc, chans;
		int y, x, ri;
		sample_t best[3];
		sample_t v;
		min_result_t res;
		chans = k_rgb ? 3 : 1;
		ri = k_rad;
		if (cur_col >= k_wid) cur_col = 0;
		if (cur_row < k_hgt) begin
			if (it.drain) return;
			rows_mem[mem_idx(cur_row, cur_col)][0] = it.r;
			rows_mem[mem_idx(cur_row, cur_col)][1] = it.g;
			rows_mem[mem_idx(cur_row, cur_col)][2] = it.b;
		end
		p = cur_row * k_wid + cur_col;
		lag = k_rad * k_wid + k_rad;
		cur_col++;
		if (cur_col >= k_wid) begin
			cur_col = 0;
			cur_row++;
		end
		if (p < lag) return;
		q = p - lag;
		rc = q / k_wid;
		cc = q % k_wid;
		for (int ch = 0; ch < 3; ch++)
			best[ch] = (ch < chans) ? rows_mem[mem_idx(rc, cc)][ch] : '0;
		for (int dy = -ri; dy <= ri; dy++) begin
			y = int'(rc) + dy;
			if (y < ri || y >= int'(k_hgt) - ri) continue;
			for (int dx = -ri; dx <= ri; dx++) begin
				x = int'(cc) + dx;
				if (x < ri || x >= int'(k_wid) - ri) continue;
				for (int ch = 0; ch < chans; ch++) begin
					v = rows_mem[mem_idx(y, x)][ch];
					if (v < best[ch]) best[ch] = v;
				end
			end
		end
		res.r = best[0];
		res.g = best[1];
		res.b = best[2];
		res.col = cc[COORD_W-1:0];
		res.row = rc[COORD_W-1:0];
		res.fend = (q == k_hgt * k_wid - 1);
		if (res.fend) begin
			cur_col = 0;
			cur_row = 0;
		end
		expected_min.push_back(res);
	endfunction

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (!s_tvalid || in_taken) begin
				if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= IN_DATA_W'({pending_px[0].b, pending_px[0].g,
						pending_px[0].r});
					s_tuser  <= pending_px[0].drain;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// the queue head leaves once its transfer happens
	always @(posedge clk) begin
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			predict_min(pending_px.pop_front());
		end
	end

	// receiver ready, with a long hold-off on request
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		min_result_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tlast, m_tdata[OUT_BITS-1:0]};
			if (expected_min.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected output transfer %h", got);
			end else begin
				exp_r = expected_min.pop_front();
				if (got !== exp_r) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch at row %0d col %0d: expected %h got %h",
							exp_r.row, exp_r.col, exp_r, got);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off > 0
				|| (pending_px.size() == 0 && expected_min.size() == 0)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 20000) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_px.size() > 0 || expected_min.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		int unsigned fld;
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		fld = val & 32'h7ff;
		// zero acts as one, oversize values clamp to the largest frame
		if (fld == 0) fld = 1;
		if (fld > 1024) fld = 1024;
		case (idx)
			REG_RADIUS: k_rad = val & 32'h3;
			REG_WIDTH:  k_wid = fld;
			REG_HEIGHT: k_hgt = fld;
			default:    k_rgb = val & 32'h1;
		endcase
		cur_col = 0;
		cur_row = 0;
	endtask

	task automatic setup(int unsigned rad, int unsigned wid, int unsigned hgt,
			int unsigned rgb);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_WIDTH, wid);
		write_reg(REG_HEIGHT, hgt);
		write_reg(REG_COLOR, rgb);
	endtask

	function automatic pix_item_t rand_px(bit drn, int kind);
		pix_item_t it;
		it.drain = drn;
		case (kind)
			1: it.r = 8'h00;
			2: it.r = 8'hff;
			default: it.r = $urandom_range(255);
		endcase
		it.g = (kind == 2) ? 8'hff : $urandom_range(255);
		it.b = (kind == 1) ? 8'h00 : $urandom_range(255);
		return it;
	endfunction

	// one frame with stray drains inside, then flush items until the frame closes
	task automatic queue_frame(int unsigned wid, int unsigned hgt, int unsigned rad,
			bit noise);
		int unsigned flush;
		flush = rad * wid + rad;
		for (int unsigned i = 0; i < wid * hgt; i++) begin
			if (noise && $urandom_range(9) == 0)
				pending_px.push_back(rand_px(1'b1, 0));
			pending_px.push_back(rand_px(1'b0, $urandom_range(5)));
		end
		for (int unsigned i = 0; i < flush; i++)
			pending_px.push_back(rand_px($urandom_range(1), 0));
	endtask

	initial begin
		int unsigned rad, wid, hgt;
		clk = 1'b0;
		errors = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RADIUS;
		cfg_data = '0;
		k_rad = 1;
		k_wid = 1024;
		k_hgt = 1024;
		k_rgb = 0;
		cur_col = 0;
		cur_row = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);

		// directed: radius 0 passthrough, extremes, single pixel frame, small frame
		setup(0, 3, 2, 1);
		pending_px.push_back(rand_px(1'b0, 1));
		pending_px.push_back(rand_px(1'b1, 0));
		pending_px.push_back(rand_px(1'b0, 2));
		for (int i = 0; i < 4; i++) pending_px.push_back(rand_px(1'b0, 0));
		wait_drained();
		setup(3, 7, 7, 0);
		queue_frame(7, 1, 3, 1'b0);
		pending_px.delete();
		setup(1, 1, 1, 0);
		queue_frame(1, 1, 1, 1'b1);
		wait_drained();
		setup(2, 5, 3, 1);
		queue_frame(5, 3, 2, 1'b1);
		wait_drained();

		// random phases over the idling profiles
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 16 : 0;
			recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 16 : 0;
			rad = ph;
			wid = $urandom_range(2 * rad + 1, 16);
			hgt = $urandom_range(2 * rad + 1, 8);
			setup(rad, wid, hgt, ph % 2);
			for (int f = 0; f < 3; f++) queue_frame(wid, hgt, rad, 1'b1);
			if (ph == 0) hold_off = 300;
			wait_drained();
		end
		setup(1, 1, 1024, 1);
		setup(1, 1, 12, 1);
		queue_frame(1, 12, 1, 1'b1);
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_min.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> square_window_min_filter.f
src/swmf_pkg.sv
src/swmf_ram.sv
src/swmf_cell.sv
src/square_window_min_filter.sv
tb/sv/testbench.sv
